FILE: rtl/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

  // Fixed point format of every complex component: 4 integer bits, FRAC_BITS fraction.
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;
  localparam int Z_W        = FRAC_BITS + 4;
  localparam int SAT_W      = 48;

  localparam int ITER_W  = 12;
  localparam int CNT_W   = 13;
  localparam int STEP_W  = 29;
  localparam int ORIG_W  = 31;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic [1:0] REG_MAX_ITER     = 2'd0;
  localparam logic [1:0] REG_COORD_STEP   = 2'd1;
  localparam logic [1:0] REG_COORD_ORIGIN = 2'd2;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(20);
  localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(2147484);
  localparam logic [ORIG_W-1:0] ORIGIN_RST   = ORIG_W'(-536870912);

  localparam logic signed [Z_W-1:0]   TWO_FX     = Z_W'(2) << FRAC_BITS;
  localparam logic signed [Z_W-1:0]   NEG_TWO_FX = -(Z_W'(2) << FRAC_BITS);
  localparam logic signed [Z_W+1:0]   FOUR_FX    = (Z_W+2)'(4) << FRAC_BITS;
  localparam logic signed [SAT_W-1:0] SAT_HI     = (SAT_W'(1) << (Z_W-1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] SAT_LO     = -(SAT_W'(1) << (Z_W-1));

  typedef struct packed {
    logic [ITER_W-1:0] max_iter;
    logic [STEP_W-1:0] coord_step;
    logic [ORIG_W-1:0] coord_origin;
  } cfg_t;

  // One item as it travels from cell to cell.
  typedef struct packed {
    logic             valid;
    logic             done;
    logic             escaped;
    logic [CNT_W-1:0] count;
    logic [Z_W-1:0]   zr;
    logic [Z_W-1:0]   zi;
    logic [Z_W-1:0]   cr;
    logic [Z_W-1:0]   ci;
  } beat_t;

  // Saturate a wide signed value into one complex component.
  function automatic logic [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
    logic [Z_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Z_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Z_W-1:0];
    end else begin
      r = v[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/mandelbrot_escape_counter_unit.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time counter. Each input beat carries one pixel (in_pixel_x,
// in_pixel_y); the unit maps it to c = (x*coord_step + coord_origin) +
// i*(y*coord_step + coord_origin) in signed fixed point with 28 fraction bits,
// iterates z = z*z + c from zero, and returns on the output channel how many
// iterations were done (0 to max_iter+1) and whether |z| reached 2. One pixel is
// in flight at a time. The cycle of acceptance computes c; the item then walks a
// ring of NUM_CELLS iteration cells, one cell and one magnitude check per cycle
// while the ring is not paused. A pixel that stops rides on as a finished beat
// to the ring exit and is then loaded into the output register. The next pixel
// can be taken as soon as a result reaches the output register, even while
// that result still waits to be taken. The ring pauses only when a finished beat
// reaches the exit while the output register is full and stalled.
// Configuration (max_iter at 0x0, coord_step at 0x4, coord_origin at 0x8) is
// written through the APB-style port and must only change while the unit is idle.

module mandelbrot_escape_counter_unit #(
  parameter int NUM_CELLS = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mbe_pkg::COORD_BITS-1:0]  in_pixel_x,
  input  logic [mbe_pkg::COORD_BITS-1:0]  in_pixel_y,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mbe_pkg::CNT_W-1:0]       out_iter_count,
  output logic                            out_escaped,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]      paddr,
  input  logic [mbe_pkg::DATA_W-1:0]      pwdata,
  output logic [mbe_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  localparam int SW = mbe_pkg::SAT_W;
  localparam int OW = mbe_pkg::ORIG_W;
  localparam int PW = mbe_pkg::COORD_BITS + mbe_pkg::STEP_W;

  mbe_pkg::cfg_t  cfg;
  mbe_pkg::beat_t setup_r;
  mbe_pkg::beat_t inject;
  mbe_pkg::beat_t exit_beat;
  mbe_pkg::beat_t ring_q [NUM_CELLS];

  logic                        busy_r;
  logic                        out_valid_r;
  logic [mbe_pkg::CNT_W-1:0]   out_count_r;
  logic                        out_escaped_r;
  logic                        accept;
  logic                        exit_done;
  logic                        adv;
  logic [PW-1:0]               prod_x, prod_y;
  logic signed [SW-1:0]        origin_w, cx_w, cy_w;

  mbe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Only one pixel is inside the unit at a time.
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;

  // The ring holds still only when a finished beat cannot leave.
  assign exit_beat = ring_q[NUM_CELLS-1];
  assign exit_done = exit_beat.valid && exit_beat.done;
  assign adv       = !(exit_done && out_valid_r && out_stall);

  // Pixel to complex point, saturated to the component range.
  assign prod_x   = PW'(in_pixel_x) * PW'(cfg.coord_step);
  assign prod_y   = PW'(in_pixel_y) * PW'(cfg.coord_step);
  assign origin_w = {{(SW-OW){cfg.coord_origin[OW-1]}}, cfg.coord_origin};
  assign cx_w     = SW'(prod_x) + origin_w;
  assign cy_w     = SW'(prod_y) + origin_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r <= '0;
    end else if (accept) begin
      setup_r.valid   <= 1'b1;
      setup_r.done    <= 1'b0;
      setup_r.escaped <= 1'b0;
      setup_r.count   <= '0;
      setup_r.zr      <= '0;
      setup_r.zi      <= '0;
      setup_r.cr      <= mbe_pkg::sat_z(cx_w);
      setup_r.ci      <= mbe_pkg::sat_z(cy_w);
    end else if (adv) begin
      setup_r.valid <= 1'b0;
    end
  end

  // A new point enters the ring at the first cell; an unfinished one wraps around.
  always_comb begin
    if (setup_r.valid) begin
      inject = setup_r;
    end else begin
      inject       = exit_beat;
      inject.valid = exit_beat.valid && !exit_beat.done;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      mbe_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .max_iter (cfg.max_iter),
        .beat_in  (inject),
        .beat_out (ring_q[k])
      );
    end else begin : g_body
      mbe_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .max_iter (cfg.max_iter),
        .beat_in  (ring_q[k-1]),
        .beat_out (ring_q[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (exit_done && adv) begin
      busy_r <= 1'b0;
    end
  end

  // Output register: loads a finished beat, so the ring never waits on a taken result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exit_done && adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exit_done && adv) begin
      out_count_r   <= exit_beat.count;
      out_escaped_r <= exit_beat.escaped;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_iter_count = out_count_r;
  assign out_escaped    = out_escaped_r;

endmodule

FILE: rtl/mbe_cfg.sv
`timescale 1ns / 1ps

module mbe_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::DATA_W-1:0]  pwdata,
  output logic [mbe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mbe_pkg::cfg_t               cfg
);

  mbe_pkg::cfg_t cfg_r;
  mbe_pkg::cfg_t cfg_nxt;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        mbe_pkg::REG_MAX_ITER:     cfg_nxt.max_iter     = pwdata[mbe_pkg::ITER_W-1:0];
        mbe_pkg::REG_COORD_STEP:   cfg_nxt.coord_step   = pwdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_COORD_ORIGIN: cfg_nxt.coord_origin = pwdata[mbe_pkg::ORIG_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mbe_pkg::REG_MAX_ITER:
        prdata = mbe_pkg::DATA_W'(cfg_r.max_iter);
      mbe_pkg::REG_COORD_STEP:
        prdata = mbe_pkg::DATA_W'(cfg_r.coord_step);
      mbe_pkg::REG_COORD_ORIGIN:
        prdata = {{(mbe_pkg::DATA_W-mbe_pkg::ORIG_W){cfg_r.coord_origin[mbe_pkg::ORIG_W-1]}},
                  cfg_r.coord_origin};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iter     <= mbe_pkg::MAX_ITER_RST;
      cfg_r.coord_step   <= mbe_pkg::STEP_RST;
      cfg_r.coord_origin <= mbe_pkg::ORIGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/mbe_cell.sv
`timescale 1ns / 1ps

module mbe_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [mbe_pkg::ITER_W-1:0]  max_iter,
  input  mbe_pkg::beat_t              beat_in,
  output mbe_pkg::beat_t              beat_out
);

  localparam int ZW = mbe_pkg::Z_W;
  localparam int FB = mbe_pkg::FRAC_BITS;
  localparam int SW = mbe_pkg::SAT_W;

  logic signed [ZW-1:0]   zr, zi, cr, ci;
  logic signed [2*ZW-1:0] p_rr, p_ii, p_ri;
  logic signed [ZW+1:0]   sr, si, pri, mag, nr_w, ni_w;
  logic                   big, esc, stop;
  mbe_pkg::beat_t         beat_r;
  mbe_pkg::beat_t         beat_nxt;

  assign zr = beat_in.zr;
  assign zi = beat_in.zi;
  assign cr = beat_in.cr;
  assign ci = beat_in.ci;

  assign p_rr = zr * zr;
  assign p_ii = zi * zi;
  assign p_ri = zr * zi;

  // Taking the bits above the fraction floors the product.
  assign sr  = p_rr[FB +: ZW+2];
  assign si  = p_ii[FB +: ZW+2];
  assign pri = p_ri[FB +: ZW+2];
  assign mag = sr + si;

  assign big = (zr >= mbe_pkg::TWO_FX) || (zr <= mbe_pkg::NEG_TWO_FX) ||
               (zi >= mbe_pkg::TWO_FX) || (zi <= mbe_pkg::NEG_TWO_FX);
  assign esc  = big || (mag >= mbe_pkg::FOUR_FX);
  assign stop = esc || (beat_in.count > {1'b0, max_iter});

  assign nr_w = sr - si + {{2{cr[ZW-1]}}, cr};
  assign ni_w = {pri[ZW:0], 1'b0} + {{2{ci[ZW-1]}}, ci};

  always_comb begin
    beat_nxt = beat_in;
    if (beat_in.valid && !beat_in.done) begin
      if (stop) begin
        beat_nxt.done    = 1'b1;
        beat_nxt.escaped = esc;
      end else begin
        beat_nxt.zr    = mbe_pkg::sat_z({{(SW-ZW-2){nr_w[ZW+1]}}, nr_w});
        beat_nxt.zi    = mbe_pkg::sat_z({{(SW-ZW-2){ni_w[ZW+1]}}, ni_w});
        beat_nxt.count = beat_in.count + mbe_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_out = beat_r;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam longint ONE_Q = longint'(1) << mbe_pkg::FRAC_BITS;
  localparam longint Z_MAX = 8 * ONE_Q - 1;
  localparam longint Z_MIN = -8 * ONE_Q;

  typedef struct {
    logic [mbe_pkg::CNT_W-1:0] iter_count;
    logic                      escaped;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mbe_pkg::COORD_BITS-1:0] in_pixel_x = '0;
  logic [mbe_pkg::COORD_BITS-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mbe_pkg::CNT_W-1:0] out_iter_count;
  logic out_escaped;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mbe_pkg::ADDR_W-1:0] paddr = '0;
  logic [mbe_pkg::DATA_W-1:0] pwdata = '0;
  logic [mbe_pkg::DATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the unit's registers, kept as plain integers for the math.
  int unsigned iter_limit;
  longint pixel_step;
  longint plane_origin;

  escape_result_t pending_counts[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  always #1 clk = ~clk;

  mandelbrot_escape_counter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_iter_count(out_iter_count), .out_escaped(out_escaped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint clamp_z(input longint v);
    if (v > Z_MAX) return Z_MAX;
    if (v < Z_MIN) return Z_MIN;
    return v;
  endfunction

  // Fixed point product, floored like an arithmetic shift of the full product.
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> mbe_pkg::FRAC_BITS;
  endfunction

  function automatic escape_result_t predict_escape(
      input logic [mbe_pkg::COORD_BITS-1:0] px,
      input logic [mbe_pkg::COORD_BITS-1:0] py);
    escape_result_t r;
    longint cr, ci, zr, zi, sr, si, nr;
    int unsigned n;
    bit big;
    cr = clamp_z(longint'(px) * pixel_step + plane_origin);
    ci = clamp_z(longint'(py) * pixel_step + plane_origin);
    zr = 0;
    zi = 0;
    n = 0;
    forever begin
      sr = 0;
      si = 0;
      // A component at or beyond 2 in magnitude means escape without squaring.
      big = (zr >= 2 * ONE_Q) || (zr <= -2 * ONE_Q) || (zi >= 2 * ONE_Q) || (zi <= -2 * ONE_Q);
      if (!big) begin
        sr = fx_mul(zr, zr);
        si = fx_mul(zi, zi);
        big = (sr + si) >= 4 * ONE_Q;
      end
      if (n > iter_limit || big) break;
      nr = clamp_z(sr - si + cr);
      zi = clamp_z(2 * fx_mul(zr, zi) + ci);
      zr = nr;
      n++;
    end
    r.iter_count = mbe_pkg::CNT_W'(n);
    r.escaped = big;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none during quiet stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver side: random stall pattern on the result channel.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // Every result beat is compared against the oldest prediction.
  always @(posedge clk) begin
    escape_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result: iter_count %0d escaped %0d", out_iter_count, out_escaped);
        errors++;
      end else begin
        exp_r = pending_counts.pop_front();
        if (out_iter_count !== exp_r.iter_count) begin
          $error("iter_count expected %0d actual %0d", exp_r.iter_count, out_iter_count);
          errors++;
        end
        if (out_escaped !== exp_r.escaped) begin
          $error("escaped expected %0d actual %0d", exp_r.escaped, out_escaped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("mandelbrot_escape_counter_unit regression: fail");
      $finish;
    end
  end

  // Setup cycle then access cycle; the register takes the value on the access edge.
  task automatic write_reg(input logic [1:0] idx, input logic [mbe_pkg::DATA_W-1:0] val);
    longint v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mbe_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mbe_pkg::REG_MAX_ITER: iter_limit = val & 32'hFFF;
      mbe_pkg::REG_COORD_STEP: pixel_step = val & 32'h1FFF_FFFF;
      mbe_pkg::REG_COORD_ORIGIN: begin
        v = val & 32'h7FFF_FFFF;
        plane_origin = v[30] ? v - (longint'(1) << 31) : v;
      end
      default: ;
    endcase
  endtask

  task automatic set_view(input int unsigned lim, input longint step, input longint orig);
    write_reg(mbe_pkg::REG_MAX_ITER, mbe_pkg::DATA_W'(lim));
    write_reg(mbe_pkg::REG_COORD_STEP, mbe_pkg::DATA_W'(step));
    write_reg(mbe_pkg::REG_COORD_ORIGIN, mbe_pkg::DATA_W'(orig));
  endtask

  // Drives one pixel and holds it until the unit takes the beat.
  task automatic send_pixel(input logic [mbe_pkg::COORD_BITS-1:0] x,
                            input logic [mbe_pkg::COORD_BITS-1:0] y);
    int gap;
    in_valid <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (in_stall);
    pending_counts.push_back(predict_escape(x, y));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets the unit go idle so that registers may be written safely.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_view();
    // Corners of the default view, the origin of the plane and a point inside.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(250, 250);
    send_pixel(125, 250);
    send_pixel(2730, 1365);
    send_pixel(200, 300);
    drain();
  endtask

  task automatic test_limits();
    // A zero limit stops every pixel after at most one iteration.
    set_view(0, 2147484, -536870912);
    send_pixel(250, 250);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    drain();
    // The largest limit on points inside the set gives the largest count.
    write_reg(mbe_pkg::REG_MAX_ITER, 4095);
    send_pixel(250, 250);
    send_pixel(240, 260);
    send_pixel(0, 250);
    drain();
  endtask

  task automatic test_extreme_planes();
    // A zero step maps every pixel onto the origin.
    set_view(30, 0, 0);
    send_pixel(4095, 17);
    drain();
    write_reg(mbe_pkg::REG_COORD_ORIGIN, -1073741824);
    send_pixel(1, 4095);
    drain();
    // A step of one and the extreme origins push c into saturation.
    set_view(25, 268435456, 1073741823);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    drain();
    write_reg(mbe_pkg::REG_COORD_ORIGIN, -1073741824);
    send_pixel(4095, 4095);
    send_pixel(2, 0);
    send_pixel(4, 4);
    drain();
  endtask

  task automatic test_random_views(input int per_view);
    int unsigned span;
    longint step, orig;
    for (int v = 0; v < 6; v++) begin
      step = $urandom_range(1 << 18, 1 << 22);
      orig = -longint'($urandom_range(ONE_Q / 2, 5 * ONE_Q / 2));
      if (v == 5) orig = longint'($urandom) - (longint'(1) << 31);
      set_view($urandom_range(0, 80), step, orig);
      span = 32'((4 * ONE_Q) / step);
      if (span > 4095) span = 4095;
      quiet = (v == 2);
      for (int i = 0; i < per_view; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          send_pixel(mbe_pkg::COORD_BITS'($urandom_range(0, span)),
                     mbe_pkg::COORD_BITS'($urandom_range(0, span)));
        end else begin
          send_pixel(mbe_pkg::COORD_BITS'($urandom_range(0, 4095)),
                     mbe_pkg::COORD_BITS'($urandom_range(0, 4095)));
        end
      end
      quiet = 1'b0;
      drain();
    end
  endtask

  task automatic test_pause();
    // The sender holds off until every result is back, then resumes.
    set_view(20, 2147484, -536870912);
    for (int i = 0; i < 60; i++) begin
      send_pixel(mbe_pkg::COORD_BITS'($urandom_range(0, 500)),
                 mbe_pkg::COORD_BITS'($urandom_range(0, 500)));
      if (i == 30) drain();
    end
    drain();
  endtask

  initial begin
    iter_limit = 20;
    pixel_step = 2147484;
    plane_origin = -536870912;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_limits();
    test_extreme_planes();
    test_random_views(90);
    test_pause();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("mandelbrot_escape_counter_unit regression: pass");
    end else begin
      $display("mandelbrot_escape_counter_unit regression: fail");
    end
    $finish;
  end

endmodule
